### rtl/core/circle_segment_contact_test_core_macros.svh
// Assertion macros shared by the contact test checker.
// No dependencies; pulled in by `include.
`ifndef CIRCLE_SEGMENT_CONTACT_TEST_CORE_MACROS_SVH
`define CIRCLE_SEGMENT_CONTACT_TEST_CORE_MACROS_SVH

// Same-cycle implication under active-low reset.
`define CSCT_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("contact test check failed");

// Next-cycle implication under active-low reset.
`define CSCT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("contact test check failed");

`endif

### rtl/core/csct_pkg.sv
// Types, widths and the square root step for the circle/segment contact test.
// No dependencies.
package csct_pkg;

    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 20;
    localparam int RADIUS_W  = 19;
    localparam int TOL_W     = 16;
    localparam int PROBE_W   = 22;
    localparam int MAG_W     = 21;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int RAD_W     = 44;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LANES     = 9;
    localparam int PROBES    = 4;
    localparam int NSTG      = ROOT_W + 3;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((1 << FRAC_BITS) + 5) / 10);

    typedef logic signed [PROBE_W-1:0] probe_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_z;
        logic [RADIUS_W-1:0]       radius;
        logic signed [COORD_W-1:0] seg_ax;
        logic signed [COORD_W-1:0] seg_az;
        logic signed [COORD_W-1:0] seg_bx;
        logic signed [COORD_W-1:0] seg_bz;
    } req_t;

    typedef struct packed {
        logic hit_north;
        logic hit_east;
        logic hit_south;
        logic hit_west;
    } rsp_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    // One digit of the restoring integer square root.
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t            r;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = REM_W'(cur - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(cur);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag_diff(input probe_t a, input probe_t b);
        probe_t d;
        d = a - b;
        return d[PROBE_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

endpackage

### rtl/core/csct_ifs.sv
// Channel interfaces for the contact test core.
// Depends on csct_pkg.
interface csct_req_if;
    import csct_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csct_rsp_if;
    import csct_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface csct_cfg_if;
    import csct_pkg::*;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/circle_segment_contact_test_core.sv
// Circle versus line segment contact test: a word on req carries a circle and a
// segment; each rsp word gives four probe contact flags. Depends on csct_pkg
// and csct_ifs. One word is taken per clock while rsp is not stalled; the pipeline has
// one stage of differences, one of squares, 22 square root digit stages and one compare.
// Nine square roots run side by side per word, one result bit per stage.
// A stall at rsp freezes the whole pipeline; tolerance resets to 26 (0.1).
module circle_segment_contact_test_core (
    input logic      clk,
    input logic      rst_n,
    csct_cfg_if.sink cfg,
    csct_req_if.sink req,
    csct_rsp_if.source rsp
);
    import csct_pkg::*;

    logic [NSTG-1:0]     v_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [MAG_W-1:0]    mx_reg [LANES];
    logic [MAG_W-1:0]    mz_reg [LANES];
    logic [MAG_W-1:0]    mx_next [LANES];
    logic [MAG_W-1:0]    mz_next [LANES];
    sq_t                 sq_reg [LANES][ROOT_W+1];
    rsp_t                out_reg;
    rsp_t                out_next;
    logic                adv;
    probe_t              px [PROBES];
    probe_t              pz [PROBES];
    probe_t              ax, az, bx, bz, rr;

    assign adv       = !v_reg[NSTG-1] || rsp.ready;
    assign req.ready = adv;
    assign cfg.ready = 1'b1;
    assign rsp.valid = v_reg[NSTG-1];
    assign rsp.data  = out_reg;

    // Probes in order north, east, south, west.
    always_comb
    begin
        ax = PROBE_W'(req.data.seg_ax);
        az = PROBE_W'(req.data.seg_az);
        bx = PROBE_W'(req.data.seg_bx);
        bz = PROBE_W'(req.data.seg_bz);
        rr = probe_t'({{(PROBE_W-RADIUS_W){1'b0}}, req.data.radius});
        px[0] = PROBE_W'(req.data.center_x);
        pz[0] = PROBE_W'(req.data.center_z) - rr;
        px[1] = PROBE_W'(req.data.center_x) + rr;
        pz[1] = PROBE_W'(req.data.center_z);
        px[2] = PROBE_W'(req.data.center_x);
        pz[2] = PROBE_W'(req.data.center_z) + rr;
        px[3] = PROBE_W'(req.data.center_x) - rr;
        pz[3] = PROBE_W'(req.data.center_z);
        mx_next[0] = mag_diff(ax, bx);
        mz_next[0] = mag_diff(az, bz);
        for (int p = 0; p < PROBES; p++)
        begin
            mx_next[1+p]        = mag_diff(px[p], ax);
            mz_next[1+p]        = mag_diff(pz[p], az);
            mx_next[1+PROBES+p] = mag_diff(px[p], bx);
            mz_next[1+PROBES+p] = mag_diff(pz[p], bz);
        end
    end

    // Inclusive window: len - tol <= d1 + d2 <= len + tol.
    always_comb
    begin
        logic [ROOT_W:0]          s;
        logic signed [ROOT_W+2:0] diff;
        logic signed [ROOT_W+2:0] tol;
        logic [PROBES-1:0]        hit;
        tol = signed'({{(ROOT_W+3-TOL_W){1'b0}}, tol_reg});
        for (int p = 0; p < PROBES; p++)
        begin
            s = {1'b0, sq_reg[1+p][ROOT_W].root} + {1'b0, sq_reg[1+PROBES+p][ROOT_W].root};
            diff = signed'({2'b00, s}) - signed'({3'b000, sq_reg[0][ROOT_W].root});
            hit[p] = (diff >= -tol) && (diff <= tol);
        end
        out_next.hit_north = hit[0];
        out_next.hit_east  = hit[1];
        out_next.hit_south = hit[2];
        out_next.hit_west  = hit[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            tol_reg <= TOL_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                tol_reg <= cfg.data;
            end
            if (adv)
            begin
                v_reg <= {v_reg[NSTG-2:0], req.valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                mx_reg[l] <= mx_next[l];
                mz_reg[l] <= mz_next[l];
                sq_reg[l][0].rad  <= RAD_W'(SQ_W'(mx_reg[l] * mx_reg[l]))
                                   + RAD_W'(SQ_W'(mz_reg[l] * mz_reg[l]));
                sq_reg[l][0].rem  <= '0;
                sq_reg[l][0].root <= '0;
                for (int k = 0; k < ROOT_W; k++)
                begin
                    sq_reg[l][k+1] <= sqrt_step(sq_reg[l][k]);
                end
            end
            out_reg <= out_next;
        end
    end

endmodule

### rtl/core/csct_checker.sv
// Port-level checks for the contact test core, bound to its top level.
// Depends on circle_segment_contact_test_core_macros.svh and csct_pkg.
`include "circle_segment_contact_test_core_macros.svh"

module csct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input csct_pkg::rsp_t     rsp_data
);
    import csct_pkg::*;

    `CSCT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `CSCT_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_data))
    `CSCT_ASSERT_NOW(a_empty_takes, clk, rst_n, !rsp_valid, req_ready)
    `CSCT_ASSERT_NOW(a_drain_takes, clk, rst_n, rsp_ready, req_ready)

endmodule

bind circle_segment_contact_test_core csct_checker u_csct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

### tb/circle_segment_contact_test_core_scoreboard.sv
// Scoreboard for the circle/segment contact test core: watches cfg, req and rsp,
// predicts the four contact flags per request word and compares them in order.
// Depends on csct_pkg and csct_ifs.
module circle_segment_contact_test_core_scoreboard (
    input  logic clk,
    input  logic rst_n,
    csct_cfg_if  cfg,
    csct_req_if  req,
    csct_rsp_if  rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import csct_pkg::*;

    logic [TOL_W-1:0] tol_now;
    rsp_t             flags_due[$];

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= acc + bitv)
            begin
                v   = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc >>= 1;
            bitv >>= 2;
        end
        return longint'(acc);
    endfunction

    function automatic longint span(input longint x1, input longint z1,
                                    input longint x2, input longint z2);
        longint dx;
        longint dz;
        dx = x1 - x2;
        dz = z1 - z2;
        return isqrt(longint'(dx * dx + dz * dz));
    endfunction

    function automatic rsp_t contact_flags(input req_t w, input logic [TOL_W-1:0] tol);
        longint cx, cz, r, ax, az, bx, bz, len, t;
        longint px[4];
        longint pz[4];
        logic   hit[4];
        rsp_t   f;
        cx = longint'(w.center_x);
        cz = longint'(w.center_z);
        r  = longint'({1'b0, w.radius});
        ax = longint'(w.seg_ax);
        az = longint'(w.seg_az);
        bx = longint'(w.seg_bx);
        bz = longint'(w.seg_bz);
        t  = longint'({1'b0, tol});
        len = span(ax, az, bx, bz);
        // probe order: north, east, south, west
        px[0] = cx;     pz[0] = cz - r;
        px[1] = cx + r; pz[1] = cz;
        px[2] = cx;     pz[2] = cz + r;
        px[3] = cx - r; pz[3] = cz;
        for (int i = 0; i < 4; i++)
        begin
            longint s;
            s = span(px[i], pz[i], ax, az) + span(px[i], pz[i], bx, bz);
            hit[i] = (s >= len - t) && (s <= len + t);
        end
        f.hit_north = hit[0];
        f.hit_east  = hit[1];
        f.hit_south = hit[2];
        f.hit_west  = hit[3];
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_now = TOL_RESET;
            errors  = 0;
            flags_due.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tol_now = cfg.data;
            if (req.valid && req.ready)
                flags_due.push_back(contact_flags(req.data, tol_now));
            if (rsp.valid && rsp.ready)
            begin
                if (flags_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected rsp word, expected none, actual %b",
                             $time, rsp.data);
                end
                else
                begin
                    rsp_t want;
                    want = flags_due.pop_front();
                    if (want.hit_north !== rsp.data.hit_north)
                    begin
                        errors++;
                        $display("%0t: hit_north expected %b actual %b",
                                 $time, want.hit_north, rsp.data.hit_north);
                    end
                    if (want.hit_east !== rsp.data.hit_east)
                    begin
                        errors++;
                        $display("%0t: hit_east expected %b actual %b",
                                 $time, want.hit_east, rsp.data.hit_east);
                    end
                    if (want.hit_south !== rsp.data.hit_south)
                    begin
                        errors++;
                        $display("%0t: hit_south expected %b actual %b",
                                 $time, want.hit_south, rsp.data.hit_south);
                    end
                    if (want.hit_west !== rsp.data.hit_west)
                    begin
                        errors++;
                        $display("%0t: hit_west expected %b actual %b",
                                 $time, want.hit_west, rsp.data.hit_west);
                    end
                end
            end
        end
        pending = flags_due.size();
    end

endmodule

### tb/circle_segment_contact_test_core_test.sv
// Top of the contact test regression: clock, reset, cfg writes, request
// stimulus and rsp back-pressure. Depends on csct_pkg, csct_ifs, the core
// and circle_segment_contact_test_core_scoreboard.
module circle_segment_contact_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import csct_pkg::*;

    localparam int LATENCY = 25;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   stall_pct;
    int   idle_pct;

    csct_cfg_if cfg ();
    csct_req_if req ();
    csct_rsp_if rsp ();

    circle_segment_contact_test_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    circle_segment_contact_test_core_scoreboard sb (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #2000000;
        $display("circle_segment_contact_test_core regression: fail");
        $finish;
    end

    task automatic send(input req_t w);
        if ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req.valid <= 1'b1;
        req.data  <= w;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // hold off until every word is back, then let the pipeline empty out
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    task automatic write_tol(input logic [TOL_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_t make_req(input longint cx, input longint cz, input longint r,
                                      input longint ax, input longint az,
                                      input longint bx, input longint bz);
        req_t w;
        w.center_x = COORD_W'(cx);
        w.center_z = COORD_W'(cz);
        w.radius   = RADIUS_W'(r);
        w.seg_ax   = COORD_W'(ax);
        w.seg_az   = COORD_W'(az);
        w.seg_bx   = COORD_W'(bx);
        w.seg_bz   = COORD_W'(bz);
        return w;
    endfunction

    // segment laid through one of the probes, so most words hit something
    function automatic req_t aimed_req();
        longint cx, cz, r, px, pz, ux, uz, ka, kb;
        int     dir;
        cx  = longint'($urandom_range(131071)) - 65536;
        cz  = longint'($urandom_range(131071)) - 65536;
        r   = $urandom_range(4095);
        dir = $urandom_range(3);
        px  = cx + ((dir == 1) ? r : (dir == 3) ? -r : 0);
        pz  = cz + ((dir == 2) ? r : (dir == 0) ? -r : 0);
        ux  = longint'($urandom_range(4095)) - 2048;
        uz  = longint'($urandom_range(4095)) - 2048;
        ka  = $urandom_range(64);
        kb  = ($urandom_range(9) == 0) ? -ka : longint'($urandom_range(64));
        return make_req(cx, cz, r, px - ka * ux, pz - ka * uz, px + kb * ux, pz + kb * uz);
    endfunction

    function automatic req_t noise_req();
        req_t w;
        w.center_x = COORD_W'($urandom);
        w.center_z = COORD_W'($urandom);
        w.radius   = RADIUS_W'($urandom);
        w.seg_ax   = COORD_W'($urandom);
        w.seg_az   = COORD_W'($urandom);
        w.seg_bx   = COORD_W'($urandom);
        w.seg_bz   = COORD_W'($urandom);
        return w;
    endfunction

    initial
    begin
        longint lo;
        longint hi;
        lo = -524288;
        hi = 524287;
        rst_n     = 1'b0;
        stall_pct = 0;
        idle_pct  = 0;
        req.valid = 1'b0;
        req.data  = '0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset tolerance
        send(make_req(0, 0, 256, -1024, 0, 1024, 0));
        send(make_req(0, 0, 256, 0, -1024, 0, 1024));
        send(make_req(0, 0, 0, -512, -512, 512, 512));
        send(make_req(1000, -700, 0, 1000, -700, 2000, 3000));
        send(make_req(100, 100, 0, 100, 100, 100, 100));
        send(make_req(100, 100, 10, 100, 90, 100, 90));
        send(make_req(100, 100, 13, 100, 87, 100, 87));
        send(make_req(100, 100, 14, 100, 86, 100, 86));
        send(make_req(lo, lo, 0, lo, lo, hi, hi));
        send(make_req(hi, hi, 524287, lo, lo, hi, hi));
        send(make_req(lo, hi, 524287, hi, lo, lo, hi));
        send(make_req(hi, lo, 524287, hi, lo, hi, lo));
        send(make_req(lo, lo, 524287, hi, hi, hi, hi));
        send(make_req(-1, -1, 1, -1, -1, -1, -1));
        send(make_req(0, 0, 524287, 524287, 0, -524288, 0));
        send(make_req(0, 0, 300, 0, 256, 0, 1000));
        send(make_req(0, 0, 300, 0, 200, 0, 1000));
        drain();

        write_tol(16'd0);
        send(make_req(0, 0, 256, -1024, 0, 1024, 0));
        send(make_req(0, 0, 100, 3, 4, 300, 400));
        send(make_req(5, 5, 0, 5, 5, 5, 5));
        drain();
        write_tol(16'hFFFF);
        send(make_req(0, 0, 256, -1024, 0, 1024, 0));
        send(make_req(hi, hi, 524287, lo, lo, lo, lo));
        send(make_req(0, 0, 1000, 20000, 20000, 20000, 20000));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  write_tol(TOL_RESET); end
                1: begin idle_pct = 85; stall_pct = 0;  write_tol(16'($urandom_range(64))); end
                2: begin idle_pct = 0;  stall_pct = 85; write_tol(16'($urandom)); end
                default: begin idle_pct = 30; stall_pct = 30; write_tol(16'd0); end
            endcase
            for (int n = 0; n < 475; n++)
            begin
                // a run of gap-free words now and then
                if (n % 100 == 50)
                    idle_pct = 0;
                else if (n % 100 == 70)
                    idle_pct = (phase == 1) ? 85 : (phase == 3) ? 30 : 0;
                if ($urandom_range(99) < 75)
                    send(aimed_req());
                else
                    send(noise_req());
            end
            drain();
        end

        stall_pct = 0;
        if (errors == 0)
            $display("circle_segment_contact_test_core regression: pass");
        else
            $display("circle_segment_contact_test_core regression: fail");
        $finish;
    end

endmodule
